// File: design/irmd_pkg.sv
// shared types, codes and reset values for the ir message deframer
package irmd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_COMPLETE   = 2'd1,
    KIND_IDLE_ABORT = 2'd2,
    KIND_REJ_ABORT  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OWN_ADDR    = 3'd0,
    REG_UNKNOWN     = 3'd1,
    REG_MAX_SENDER  = 3'd2,
    REG_MARK_FIRST  = 3'd3,
    REG_MARK_SECOND = 3'd4,
    REG_MARK_THIRD  = 3'd5,
    REG_IDLE_LIMIT  = 3'd6,
    REG_REJ_LIMIT   = 3'd7
  } reg_idx_e;

  // register reset values
  localparam logic [7:0] RST_OWN_ADDR    = 8'd0;
  localparam logic [7:0] RST_UNKNOWN     = 8'd255;
  localparam logic [7:0] RST_MAX_SENDER  = 8'd99;
  localparam logic [7:0] RST_MARK_FIRST  = 8'd240;
  localparam logic [7:0] RST_MARK_SECOND = 8'd241;
  localparam logic [7:0] RST_MARK_THIRD  = 8'd242;
  localparam logic [7:0] RST_IDLE_LIMIT  = 8'd10;
  localparam logic [7:0] RST_REJ_LIMIT   = 8'd40;

  // length saturation default
  localparam int MaxLengthDefault = 255;

  // result queue geometry
  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] total;
    logic       last;
  } result_t;

endpackage

// File: design/ir_message_deframer.sv
// ir message deframer: frame filtering, end mark matching and result queue
// results of an input transfer are registered into the result queue before they are offered
// throughput: one input per cycle while each causes at most one result and the
//   output drains; a queue of four results takes new input only with three free slots
// reset: registers return to their defaults, the block waits for a message,
//   and the result queue is empty
module ir_message_deframer #(
  parameter int MAX_LENGTH = irmd_pkg::MaxLengthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] sender_address_i,
  input  logic [7:0] command_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_total_o,
  output logic       last_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_LENGTH);

  // configuration registers
  logic [7:0] own_q, unknown_q, max_sender_q, mark1_q, mark2_q, mark3_q;
  logic [7:0] idle_lim_q, rej_lim_q;

  // message state
  logic       rx_q, rx_d;
  logic       seen1_q, seen1_d;
  logic       seen2_q, seen2_d;
  logic [7:0] last_q, last_d;
  logic [7:0] count_q, count_d;
  logic [7:0] idle_q, idle_d;
  logic [7:0] rej_q, rej_d;

  // result queue
  irmd_pkg::result_t               queue_q [irmd_pkg::QueueDepth];
  logic [irmd_pkg::PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [irmd_pkg::CntW-1:0]       fill_q;

  // per-item results
  irmd_pkg::result_t res [irmd_pkg::MaxResults];
  logic [1:0]        res_n;
  logic [1:0]        res_n_raw;
  logic [7:0]        cnt;
  logic [7:0]        idle_inc, rej_inc;
  logic              in_xfer, out_xfer, rejected, own_or_unknown;

  assign in_ready_o = fill_q <= irmd_pkg::CntW'(irmd_pkg::QueueDepth - irmd_pkg::MaxResults);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = fill_q != '0;
  assign out_xfer   = out_valid_o && out_ready_i;

  assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
  assign rej_inc  = (rej_q == 8'hFF) ? rej_q : rej_q + 8'd1;
  assign own_or_unknown = (sender_address_i == own_q) || (sender_address_i == unknown_q);
  assign rejected = own_or_unknown || (sender_address_i > max_sender_q);

  // frame processing
  always_comb begin
    rx_d      = rx_q;
    seen1_d   = seen1_q;
    seen2_d   = seen2_q;
    last_d    = last_q;
    count_d   = count_q;
    idle_d    = idle_q;
    rej_d     = rej_q;
    res_n_raw = 2'd0;
    cnt       = count_q;
    for (int k = 0; k < irmd_pkg::MaxResults; k++) begin
      res[k] = '{kind: irmd_pkg::KIND_DATA, data: 8'd0, total: 8'd0, last: 1'b0};
    end
    if (in_xfer) begin
      if (!rx_q) begin
        // opening frame
        if (!action_i && !own_or_unknown) begin
          rx_d = 1'b1; seen1_d = 1'b0; seen2_d = 1'b0; last_d = 8'd0;
          count_d = 8'd0; idle_d = 8'd0; rej_d = 8'd0;
        end
      end else if (action_i) begin
        // empty tick
        idle_d = idle_inc;
        if (idle_inc >= idle_lim_q) begin
          res[0] = '{kind: irmd_pkg::KIND_IDLE_ABORT, data: 8'd0, total: count_q, last: 1'b0};
          res_n_raw = 2'd1;
          rx_d = 1'b0; seen1_d = 1'b0; seen2_d = 1'b0; last_d = 8'd0;
          count_d = 8'd0; idle_d = 8'd0; rej_d = 8'd0;
        end
      end else begin
        idle_d = 8'd0;
        priority if (rejected) begin
          rej_d = rej_inc;
          if (rej_inc >= rej_lim_q) begin
            res[0] = '{kind: irmd_pkg::KIND_REJ_ABORT, data: 8'd0, total: count_q, last: 1'b0};
            res_n_raw = 2'd1;
            rx_d = 1'b0; seen1_d = 1'b0; seen2_d = 1'b0; last_d = 8'd0;
            count_d = 8'd0; rej_d = 8'd0;
          end
        end else if (count_q != 8'd0 && command_byte_i == last_q) begin
          // repeat of last stored byte
        end else if (!seen1_q && command_byte_i == mark1_q) begin
          seen1_d = 1'b1;
        end else if (seen1_q && !seen2_q && command_byte_i == mark2_q) begin
          seen2_d = 1'b1;
        end else if (seen1_q && seen2_q && command_byte_i == mark3_q) begin
          res[0] = '{kind: irmd_pkg::KIND_COMPLETE, data: 8'd0, total: count_q, last: 1'b0};
          res_n_raw = 2'd1;
          rx_d = 1'b0; seen1_d = 1'b0; seen2_d = 1'b0; last_d = 8'd0;
          count_d = 8'd0; rej_d = 8'd0;
        end else if (seen2_q && command_byte_i == mark2_q) begin
          // repeated second mark byte
        end else if (seen1_q && command_byte_i == mark1_q) begin
          // repeated first mark byte
        end else begin
          // flush broken mark, then store the byte
          if (seen1_q) begin
            cnt = (cnt < MaxLen) ? cnt + 8'd1 : cnt;
            res[res_n_raw] = '{kind: irmd_pkg::KIND_DATA, data: mark1_q, total: cnt,
                               last: 1'b0};
            res_n_raw = res_n_raw + 2'd1;
          end
          if (seen2_q) begin
            cnt = (cnt < MaxLen) ? cnt + 8'd1 : cnt;
            res[res_n_raw] = '{kind: irmd_pkg::KIND_DATA, data: mark2_q, total: cnt,
                               last: 1'b0};
            res_n_raw = res_n_raw + 2'd1;
          end
          cnt = (cnt < MaxLen) ? cnt + 8'd1 : cnt;
          res[res_n_raw] = '{kind: irmd_pkg::KIND_DATA, data: command_byte_i, total: cnt,
                             last: 1'b0};
          res_n_raw = res_n_raw + 2'd1;
          seen1_d = 1'b0;
          seen2_d = 1'b0;
          last_d  = command_byte_i;
          count_d = cnt;
        end
      end
    end
    // mark the final result of this item
    for (int k = 0; k < irmd_pkg::MaxResults; k++) begin
      res[k].last = (2'(k) == res_n_raw - 2'd1) && (res_n_raw != 2'd0);
    end
    res_n = res_n_raw;
  end

  // configuration and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q        <= irmd_pkg::RST_OWN_ADDR;
      unknown_q    <= irmd_pkg::RST_UNKNOWN;
      max_sender_q <= irmd_pkg::RST_MAX_SENDER;
      mark1_q      <= irmd_pkg::RST_MARK_FIRST;
      mark2_q      <= irmd_pkg::RST_MARK_SECOND;
      mark3_q      <= irmd_pkg::RST_MARK_THIRD;
      idle_lim_q   <= irmd_pkg::RST_IDLE_LIMIT;
      rej_lim_q    <= irmd_pkg::RST_REJ_LIMIT;
      rx_q         <= 1'b0;
      seen1_q      <= 1'b0;
      seen2_q      <= 1'b0;
      last_q       <= 8'd0;
      count_q      <= 8'd0;
      idle_q       <= 8'd0;
      rej_q        <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (irmd_pkg::reg_idx_e'(cfg_idx_i))
          irmd_pkg::REG_OWN_ADDR:    own_q        <= cfg_data_i;
          irmd_pkg::REG_UNKNOWN:     unknown_q    <= cfg_data_i;
          irmd_pkg::REG_MAX_SENDER:  max_sender_q <= cfg_data_i;
          irmd_pkg::REG_MARK_FIRST:  mark1_q      <= cfg_data_i;
          irmd_pkg::REG_MARK_SECOND: mark2_q      <= cfg_data_i;
          irmd_pkg::REG_MARK_THIRD:  mark3_q      <= cfg_data_i;
          irmd_pkg::REG_IDLE_LIMIT:  idle_lim_q   <= cfg_data_i;
          irmd_pkg::REG_REJ_LIMIT:   rej_lim_q    <= cfg_data_i;
          default: ;
        endcase
      end
      rx_q    <= rx_d;
      seen1_q <= seen1_d;
      seen2_q <= seen2_d;
      last_q  <= last_d;
      count_q <= count_d;
      idle_q  <= idle_d;
      rej_q   <= rej_d;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + irmd_pkg::PtrW'(res_n);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + irmd_pkg::PtrW'(1);
      end
      fill_q <= fill_q + irmd_pkg::CntW'(res_n) - irmd_pkg::CntW'(out_xfer);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < irmd_pkg::MaxResults; k++) begin
      if (2'(k) < res_n) begin
        queue_q[wr_ptr_q + irmd_pkg::PtrW'(k)] <= res[k];
      end
    end
  end

  // output transfer fields
  assign kind_o       = queue_q[rd_ptr_q].kind;
  assign data_byte_o  = queue_q[rd_ptr_q].data;
  assign byte_total_o = queue_q[rd_ptr_q].total;
  assign last_o       = queue_q[rd_ptr_q].last;

endmodule
